FILE: rtl/core/lrmt_pkg.sv
// ----------------------------------------------------------------------------
// lrmt_pkg
// Shared types, constants and node arithmetic for the range maximum tree.
// ----------------------------------------------------------------------------
package lrmt_pkg;

   localparam int LEAF_LOG   = 10;
   localparam int LEAF_COUNT = 1 << LEAF_LOG;
   localparam int NODE_COUNT = 2 * LEAF_COUNT;
   localparam int NODE_W     = LEAF_LOG + 1;
   localparam int LVL_W      = $clog2(LEAF_LOG + 1);
   localparam int RANGE_W    = 11;
   localparam int DATA_W     = 64;

   localparam logic [DATA_W-1:0] NEUTRAL = {4'hF, {(DATA_W-4){1'b0}}};

   localparam logic [1:0] FUNC_ASSIGN = 2'd0;
   localparam logic [1:0] FUNC_ADD    = 2'd1;
   localparam logic [1:0] FUNC_QUERY  = 2'd2;

   typedef struct packed {
      logic [DATA_W-1:0] max_v;
      logic              av;
      logic [DATA_W-1:0] aval;
      logic [DATA_W-1:0] addend;
   } rec_type;

   typedef enum logic [1:0] {RD_NONE, RD_NODE, RD_LEFT, RD_RIGHT} rd_sel_type;
   typedef enum logic [1:0] {CAP_NONE, CAP_PAR, CAP_LEFT, CAP_RIGHT} cap_type;
   typedef enum logic [2:0] {WR_NONE, WR_CLEAR, WR_COVER, WR_PUSH_L, WR_PUSH_R,
                             WR_FIX} wr_op_type;
   typedef enum logic [1:0] {MV_NONE, MV_LEFT, MV_SIB, MV_UP} mv_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_VISIT_RD, ST_VISIT_CAP, ST_VISIT_EVAL,
      ST_PUSH_RDR, ST_PUSH_CAPR, ST_PUSH_WR, ST_PUSH_PAR, ST_RET,
      ST_FIX_RDL, ST_FIX_RDR, ST_FIX_CAP, ST_FIX_WR, ST_FINISH
   } ctl_state_type;

   typedef struct packed {
      logic       load_req;
      rd_sel_type rd_sel;
      cap_type    cap;
      wr_op_type  wr;
      mv_type     mv;
      logic       acc_node;
      logic       rsp_load;
      logic       clr_step;
   } ctl_cmd_type;

   typedef struct packed {
      logic       disjoint;
      logic       covered;
      logic       is_root;
      logic       is_left;
      logic       clr_last;
      logic       is_query;
      logic       is_assign;
      logic       rsp_free;
   } ctl_stat_type;

   function automatic logic [DATA_W-1:0] smax(input logic [DATA_W-1:0] a,
                                              input logic [DATA_W-1:0] b);
      return ($signed(a) >= $signed(b)) ? a : b;
   endfunction

   function automatic logic [DATA_W-1:0] rec_value(input rec_type r);
      return (r.av ? r.aval : r.max_v) + r.addend;
   endfunction

   function automatic rec_type merge(input rec_type r, input logic has_set,
                                     input logic [DATA_W-1:0] set_val,
                                     input logic [DATA_W-1:0] add);
      rec_type m;
      m = r;
      if (has_set) begin
         m.av     = 1'b1;
         m.aval   = set_val;
         m.addend = add;
      end else begin
         m.addend = r.addend + add;
      end
      return m;
   endfunction

endpackage

FILE: rtl/core/lrmt_datapath.sv
// ----------------------------------------------------------------------------
// lrmt_datapath
// Node memory, walk position, working records, running maximum and result
// register of the range maximum tree.
// ----------------------------------------------------------------------------
module lrmt_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [1:0]                     req_func,
   input  logic [lrmt_pkg::RANGE_W-1:0]   req_range_start,
   input  logic [lrmt_pkg::RANGE_W-1:0]   req_range_end,
   input  logic signed [lrmt_pkg::DATA_W-1:0] req_operand,
   input  lrmt_pkg::ctl_cmd_type          cmd,
   output lrmt_pkg::ctl_stat_type         stat,
   input  logic                           rsp_stall,
   output logic                           rsp_valid,
   output logic signed [lrmt_pkg::DATA_W-1:0] rsp_max_value
);

   lrmt_pkg::rec_type mem [lrmt_pkg::NODE_COUNT];

   logic [1:0]                   func_ff;
   logic [lrmt_pkg::RANGE_W-1:0] qs_ff, qe_ff;
   logic [lrmt_pkg::DATA_W-1:0]  opnd_ff;
   logic [lrmt_pkg::NODE_W-1:0]  node_ff, node_in;
   logic [lrmt_pkg::LVL_W-1:0]   lvl_ff, lvl_in;
   logic [lrmt_pkg::NODE_W-1:0]  clr_ff;
   lrmt_pkg::rec_type            rd_ff, par_ff, left_ff, right_ff;
   logic [lrmt_pkg::DATA_W-1:0]  acc_ff;
   logic                         rsp_valid_ff;
   logic [lrmt_pkg::DATA_W-1:0]  rsp_max_ff;

   logic [lrmt_pkg::NODE_W-1:0]  left_addr, right_addr, rd_addr, wr_addr;
   logic                         wr_en;
   lrmt_pkg::rec_type            wr_data, cover_rec, push_l_rec, push_r_rec, fix_rec;
   logic [lrmt_pkg::LVL_W-1:0]   sh;
   logic [lrmt_pkg::NODE_W-1:0]  shl;
   logic [lrmt_pkg::RANGE_W-1:0] lo, hi;
   logic                         has_set;

   assign left_addr  = {node_ff[lrmt_pkg::NODE_W-2:0], 1'b0};
   assign right_addr = {node_ff[lrmt_pkg::NODE_W-2:0], 1'b1};
   assign has_set    = (func_ff == lrmt_pkg::FUNC_ASSIGN);

   assign sh  = lrmt_pkg::LVL_W'(lrmt_pkg::LEAF_LOG) - lvl_ff;
   assign shl = node_ff << sh;
   assign lo  = lrmt_pkg::RANGE_W'(shl[lrmt_pkg::LEAF_LOG-1:0]);
   assign hi  = lo + lrmt_pkg::RANGE_W'(lrmt_pkg::NODE_W'(1) << sh);

   always_comb begin
      cover_rec  = lrmt_pkg::merge(par_ff, has_set, opnd_ff,
                                   has_set ? '0 : opnd_ff);
      push_l_rec = lrmt_pkg::merge(left_ff, par_ff.av, par_ff.aval, par_ff.addend);
      push_r_rec = lrmt_pkg::merge(right_ff, par_ff.av, par_ff.aval, par_ff.addend);
      fix_rec        = '0;
      fix_rec.max_v  = lrmt_pkg::smax(lrmt_pkg::rec_value(left_ff),
                                      lrmt_pkg::rec_value(right_ff));
   end

   always_comb begin
      unique case (cmd.rd_sel)
         lrmt_pkg::RD_NODE:  rd_addr = node_ff;
         lrmt_pkg::RD_LEFT:  rd_addr = left_addr;
         lrmt_pkg::RD_RIGHT: rd_addr = right_addr;
         default:            rd_addr = node_ff;
      endcase
   end

   always_comb begin
      wr_en   = 1'b1;
      wr_addr = node_ff;
      wr_data = fix_rec;
      unique case (cmd.wr)
         lrmt_pkg::WR_CLEAR: begin
            wr_addr = clr_ff;
            wr_data = '{max_v: lrmt_pkg::NEUTRAL, av: 1'b0, aval: '0, addend: '0};
         end
         lrmt_pkg::WR_COVER:  wr_data = cover_rec;
         lrmt_pkg::WR_PUSH_L: begin
            wr_addr = left_addr;
            wr_data = push_l_rec;
         end
         lrmt_pkg::WR_PUSH_R: begin
            wr_addr = right_addr;
            wr_data = push_r_rec;
         end
         lrmt_pkg::WR_FIX:    wr_data = fix_rec;
         default:             wr_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_sel != lrmt_pkg::RD_NONE) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      node_in = node_ff;
      lvl_in  = lvl_ff;
      if (cmd.load_req) begin
         node_in = lrmt_pkg::NODE_W'(1);
         lvl_in  = '0;
      end else begin
         case (cmd.mv)
            lrmt_pkg::MV_LEFT: begin
               node_in = left_addr;
               lvl_in  = lvl_ff + lrmt_pkg::LVL_W'(1);
            end
            lrmt_pkg::MV_SIB:  node_in = {node_ff[lrmt_pkg::NODE_W-1:1], 1'b1};
            lrmt_pkg::MV_UP: begin
               node_in = node_ff >> 1;
               lvl_in  = lvl_ff - lrmt_pkg::LVL_W'(1);
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_ff      <= lrmt_pkg::NODE_W'(1);
         lvl_ff       <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         node_ff <= node_in;
         lvl_ff  <= lvl_in;
         if (cmd.clr_step) begin
            clr_ff <= clr_ff + lrmt_pkg::NODE_W'(1);
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         func_ff <= lrmt_pkg::FUNC_ASSIGN;
         qs_ff   <= '0;
         qe_ff   <= '0;
      end else if (cmd.load_req) begin
         func_ff <= req_func;
         qs_ff   <= req_range_start;
         qe_ff   <= req_range_end;
         opnd_ff <= req_operand;
         acc_ff  <= lrmt_pkg::NEUTRAL;
      end else if (cmd.acc_node) begin
         acc_ff <= lrmt_pkg::smax(acc_ff, lrmt_pkg::rec_value(par_ff));
      end
      case (cmd.cap)
         lrmt_pkg::CAP_PAR:   par_ff   <= rd_ff;
         lrmt_pkg::CAP_LEFT:  left_ff  <= rd_ff;
         lrmt_pkg::CAP_RIGHT: right_ff <= rd_ff;
         default: ;
      endcase
      if (cmd.wr == lrmt_pkg::WR_PUSH_L) begin
         left_ff <= push_l_rec;
      end
      if (cmd.wr == lrmt_pkg::WR_PUSH_R) begin
         right_ff <= push_r_rec;
      end
      if (cmd.rsp_load) begin
         rsp_max_ff <= acc_ff;
      end
   end

   always_comb begin
      stat.disjoint  = (qe_ff <= lo) || (hi <= qs_ff);
      stat.covered   = (qs_ff <= lo) && (hi <= qe_ff);
      stat.is_root   = (node_ff == lrmt_pkg::NODE_W'(1));
      stat.is_left   = ~node_ff[0];
      stat.clr_last  = (clr_ff == lrmt_pkg::NODE_W'(lrmt_pkg::NODE_COUNT - 1));
      stat.is_query  = (func_ff == lrmt_pkg::FUNC_QUERY);
      stat.is_assign = has_set;
      stat.rsp_free  = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_max_value = rsp_max_ff;

endmodule

FILE: rtl/core/lrmt_ctrl.sv
// ----------------------------------------------------------------------------
// lrmt_ctrl
// Walk sequencer: clearing pass, node visits, push-down and re-merge steps.
// ----------------------------------------------------------------------------
module lrmt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [1:0]             req_func,
   output logic                   req_stall,
   input  lrmt_pkg::ctl_stat_type stat,
   output lrmt_pkg::ctl_cmd_type  cmd
);

   lrmt_pkg::ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lrmt_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      cmd       = '{load_req: 1'b0, rd_sel: lrmt_pkg::RD_NONE, cap: lrmt_pkg::CAP_NONE,
                    wr: lrmt_pkg::WR_NONE, mv: lrmt_pkg::MV_NONE, acc_node: 1'b0,
                    rsp_load: 1'b0, clr_step: 1'b0};
      unique case (state_ff)
         lrmt_pkg::ST_CLEAR: begin
            cmd.wr       = lrmt_pkg::WR_CLEAR;
            cmd.clr_step = 1'b1;
            if (stat.clr_last) state_in = lrmt_pkg::ST_IDLE;
         end
         lrmt_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               if (req_func == lrmt_pkg::FUNC_ASSIGN || req_func == lrmt_pkg::FUNC_ADD ||
                   req_func == lrmt_pkg::FUNC_QUERY) begin
                  state_in = lrmt_pkg::ST_VISIT_RD;
               end
            end
         end
         lrmt_pkg::ST_VISIT_RD: begin
            cmd.rd_sel = lrmt_pkg::RD_NODE;
            state_in   = lrmt_pkg::ST_VISIT_CAP;
         end
         lrmt_pkg::ST_VISIT_CAP: begin
            cmd.cap  = lrmt_pkg::CAP_PAR;
            state_in = lrmt_pkg::ST_VISIT_EVAL;
         end
         lrmt_pkg::ST_VISIT_EVAL: begin
            if (stat.disjoint) begin
               state_in = lrmt_pkg::ST_RET;
            end else if (stat.covered) begin
               if (stat.is_query) cmd.acc_node = 1'b1;
               else               cmd.wr       = lrmt_pkg::WR_COVER;
               state_in = lrmt_pkg::ST_RET;
            end else begin
               cmd.rd_sel = lrmt_pkg::RD_LEFT;
               state_in   = lrmt_pkg::ST_PUSH_RDR;
            end
         end
         lrmt_pkg::ST_PUSH_RDR: begin
            cmd.rd_sel = lrmt_pkg::RD_RIGHT;
            cmd.cap    = lrmt_pkg::CAP_LEFT;
            state_in   = lrmt_pkg::ST_PUSH_CAPR;
         end
         lrmt_pkg::ST_PUSH_CAPR: begin
            cmd.cap  = lrmt_pkg::CAP_RIGHT;
            cmd.wr   = lrmt_pkg::WR_PUSH_L;
            state_in = lrmt_pkg::ST_PUSH_WR;
         end
         lrmt_pkg::ST_PUSH_WR: begin
            cmd.wr   = lrmt_pkg::WR_PUSH_R;
            state_in = lrmt_pkg::ST_PUSH_PAR;
         end
         lrmt_pkg::ST_PUSH_PAR: begin
            cmd.wr   = lrmt_pkg::WR_FIX;
            cmd.mv   = lrmt_pkg::MV_LEFT;
            state_in = lrmt_pkg::ST_VISIT_RD;
         end
         lrmt_pkg::ST_RET: begin
            if (stat.is_root) begin
               state_in = lrmt_pkg::ST_FINISH;
            end else if (stat.is_left) begin
               cmd.mv   = lrmt_pkg::MV_SIB;
               state_in = lrmt_pkg::ST_VISIT_RD;
            end else begin
               cmd.mv   = lrmt_pkg::MV_UP;
               state_in = stat.is_query ? lrmt_pkg::ST_RET : lrmt_pkg::ST_FIX_RDL;
            end
         end
         lrmt_pkg::ST_FIX_RDL: begin
            cmd.rd_sel = lrmt_pkg::RD_LEFT;
            state_in   = lrmt_pkg::ST_FIX_RDR;
         end
         lrmt_pkg::ST_FIX_RDR: begin
            cmd.rd_sel = lrmt_pkg::RD_RIGHT;
            cmd.cap    = lrmt_pkg::CAP_LEFT;
            state_in   = lrmt_pkg::ST_FIX_CAP;
         end
         lrmt_pkg::ST_FIX_CAP: begin
            cmd.cap  = lrmt_pkg::CAP_RIGHT;
            state_in = lrmt_pkg::ST_FIX_WR;
         end
         lrmt_pkg::ST_FIX_WR: begin
            cmd.wr   = lrmt_pkg::WR_FIX;
            state_in = lrmt_pkg::ST_RET;
         end
         lrmt_pkg::ST_FINISH: begin
            if (!stat.is_query) begin
               state_in = lrmt_pkg::ST_IDLE;
            end else if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = lrmt_pkg::ST_IDLE;
            end
         end
         default: state_in = lrmt_pkg::ST_IDLE;
      endcase
   end

endmodule

FILE: rtl/core/lazy_range_max_tree.sv
// ----------------------------------------------------------------------------
// lazy_range_max_tree
// Lazy segment tree with range assign, range add and range maximum query.
// ----------------------------------------------------------------------------
// After reset the block clears its 2048-entry node memory, one node a cycle,
// and takes no word until that pass ends. It then takes one word at a time.
// Each word walks the tree through a single-port node memory, one record
// moved per cycle: each visited node is read, captured and evaluated; a node
// that pushes its pending work down reads both children, writes both back
// with that work merged in and rewrites itself; for assign and add each node
// on the way up is re-merged from its two children. An unknown operation is
// taken but starts no walk.
// A result waits in an output register while the next word is accepted.
// ----------------------------------------------------------------------------
module lazy_range_max_tree (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_func,
   input  logic [lrmt_pkg::RANGE_W-1:0]       req_range_start,
   input  logic [lrmt_pkg::RANGE_W-1:0]       req_range_end,
   input  logic signed [lrmt_pkg::DATA_W-1:0] req_operand,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [lrmt_pkg::DATA_W-1:0] rsp_max_value
);

   lrmt_pkg::ctl_cmd_type  cmd;
   lrmt_pkg::ctl_stat_type stat;

   lrmt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   lrmt_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_func        (req_func),
      .req_range_start (req_range_start),
      .req_range_end   (req_range_end),
      .req_operand     (req_operand),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_max_value   (rsp_max_value)
   );

   a_cls_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(stat.disjoint && stat.covered))
      else $error("node both disjoint and covered");

   a_rsp_only_query: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (stat.is_query && stat.rsp_free))
      else $error("result loaded for non-query or over a pending result");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_func == lrmt_pkg::FUNC_QUERY) |=> req_stall)
      else $error("query accepted without starting a walk");

endmodule

FILE: verif/tb_lazy_range_max_tree.sv
// ----------------------------------------------------------------------------
// tb_lazy_range_max_tree
// Drives assign, add, max-query and unknown words at the tree and checks
// every returned maximum against a lazy segment tree kept inside the bench.
// ----------------------------------------------------------------------------
module tb_lazy_range_max_tree;

   typedef struct {
      logic [1:0]        func;
      logic [10:0]       lo;
      logic [10:0]       hi;
      logic [63:0]       operand;
      bit                drain_first;
   } tree_word_type;

   localparam int SLOTS = 4096;
   localparam int IDLE_LIMIT = 20000;
   localparam logic [1:0] FUNC_NONE = 2'd3;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_func;
   logic [10:0]        req_range_start;
   logic [10:0]        req_range_end;
   logic signed [63:0] req_operand;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [63:0] rsp_max_value;

   tree_word_type word_q[$];
   logic [63:0]   max_q[$];
   logic [63:0]   t_max[SLOTS];
   bit            t_av[SLOTS];
   logic [63:0]   t_aval[SLOTS];
   logic [63:0]   t_add[SLOTS];
   bit            taken;
   int            errors;
   int            idle_cycles;
   int            cycle_cnt;
   int            burst_left;
   int            gap_left;

   lazy_range_max_tree dut (.*);

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [63:0] bigger(input logic [63:0] a, input logic [63:0] b);
      return ($signed(a) >= $signed(b)) ? a : b;
   endfunction

   function automatic logic [63:0] node_val(input int i);
      return (t_av[i] ? t_aval[i] : t_max[i]) + t_add[i];
   endfunction

   function automatic void fold_in(input int i, input bit set, input logic [63:0] sv,
                                   input logic [63:0] add);
      if (set) begin
         t_av[i]   = 1'b1;
         t_aval[i] = sv;
         t_add[i]  = add;
      end else begin
         t_add[i]  = t_add[i] + add;
      end
   endfunction

   function automatic void sink(input int i);
      fold_in(2*i, t_av[i], t_aval[i], t_add[i]);
      fold_in(2*i+1, t_av[i], t_aval[i], t_add[i]);
      t_av[i]   = 1'b0;
      t_aval[i] = '0;
      t_add[i]  = '0;
      t_max[i]  = bigger(node_val(2*i), node_val(2*i+1));
   endfunction

   function automatic logic [63:0] range_max(input int i, input int lo, input int hi,
                                             input int qs, input int qe);
      int mid;
      if (qe <= lo || hi <= qs) return lrmt_pkg::NEUTRAL;
      if (qs <= lo && hi <= qe) return node_val(i);
      if (2*i+1 >= SLOTS) return lrmt_pkg::NEUTRAL;
      sink(i);
      mid = lo + (hi - lo) / 2;
      return bigger(range_max(2*i, lo, mid, qs, qe), range_max(2*i+1, mid, hi, qs, qe));
   endfunction

   function automatic void range_write(input int i, input int lo, input int hi,
                                       input int qs, input int qe, input bit set,
                                       input logic [63:0] sv, input logic [63:0] add);
      int mid;
      if (qe <= lo || hi <= qs) return;
      if (qs <= lo && hi <= qe) begin
         fold_in(i, set, sv, add);
         return;
      end
      if (2*i+1 >= SLOTS) return;
      sink(i);
      mid = lo + (hi - lo) / 2;
      range_write(2*i, lo, mid, qs, qe, set, sv, add);
      range_write(2*i+1, mid, hi, qs, qe, set, sv, add);
      t_max[i] = bigger(node_val(2*i), node_val(2*i+1));
   endfunction

   task automatic push_word(input logic [1:0] f, input int lo, input int hi,
                            input logic [63:0] op, input bit drain = 1'b0);
      tree_word_type w;
      w.func = f;
      w.lo = lo[10:0];
      w.hi = hi[10:0];
      w.operand = op;
      w.drain_first = drain;
      word_q.insert(word_q.size(), w);
   endtask

   function automatic logic [63:0] rand_operand();
      case ($urandom_range(0, 3))
         0: return {$urandom, $urandom};
         1: return {{32{1'b1}}, $urandom} | 64'hFFFF_FFFF_FFF0_0000;
         default: return 64'($signed($urandom_range(0, 2000)) - 1000);
      endcase
   endfunction

   // driver
   always @(negedge clock) begin
      logic nv;
      if (!reset) begin
         nv = req_valid && !taken;
         if (!nv) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (word_q.size() > 0 && !(word_q[0].drain_first && max_q.size() > 0)) begin
               req_func <= word_q[0].func;
               req_range_start <= word_q[0].lo;
               req_range_end <= word_q[0].hi;
               req_operand <= word_q[0].operand;
               void'(word_q.pop_front());
               nv = 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 20);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
               end
            end
         end
         req_valid <= nv;
         case ((cycle_cnt / 512) % 4)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 1) == 1);
            2: rsp_stall <= (cycle_cnt % 64) < 40;
            default: rsp_stall <= ($urandom_range(0, 9) != 0);
         endcase
      end
   end

   // monitor and predictor
   always @(posedge clock) begin
      bit got;
      cycle_cnt++;
      taken = req_valid && !req_stall && !reset;
      got = rsp_valid && !rsp_stall && !reset;
      if (taken) begin
         case (req_func)
            lrmt_pkg::FUNC_ASSIGN: range_write(1, 0, lrmt_pkg::LEAF_COUNT, req_range_start,
                                               req_range_end, 1'b1, req_operand, '0);
            lrmt_pkg::FUNC_ADD:    range_write(1, 0, lrmt_pkg::LEAF_COUNT, req_range_start,
                                               req_range_end, 1'b0, '0, req_operand);
            lrmt_pkg::FUNC_QUERY:  max_q.insert(max_q.size(),
                                      range_max(1, 0, lrmt_pkg::LEAF_COUNT,
                                                req_range_start, req_range_end));
            default: ;
         endcase
      end
      if (got) begin
         if (max_q.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual %h", $time, rsp_max_value);
            errors++;
         end else begin
            if (rsp_max_value !== max_q[0]) begin
               $display("%0t: max_value expected %h, actual %h", $time, max_q[0],
                        rsp_max_value);
               errors++;
            end
            void'(max_q.pop_front());
         end
      end
      idle_cycles = (taken || got) ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      int lo;
      int hi;
      int r;
      logic [1:0] f;
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = '0;
      req_range_start = '0;
      req_range_end = '0;
      req_operand = '0;
      rsp_stall = 1'b0;
      taken = 1'b0;
      errors = 0;
      idle_cycles = 0;
      cycle_cnt = 0;
      burst_left = 0;
      gap_left = 0;
      for (int i = 0; i < SLOTS; i++) begin
         t_max[i] = lrmt_pkg::NEUTRAL;
         t_av[i] = 1'b0;
         t_aval[i] = '0;
         t_add[i] = '0;
      end

      push_word(lrmt_pkg::FUNC_QUERY, 0, 1024, '0);
      push_word(lrmt_pkg::FUNC_ASSIGN, 0, 1024, 64'd5);
      push_word(lrmt_pkg::FUNC_QUERY, 0, 1024, '1);
      push_word(lrmt_pkg::FUNC_QUERY, 7, 7, '0);
      push_word(lrmt_pkg::FUNC_QUERY, 10, 3, '0);
      push_word(lrmt_pkg::FUNC_ASSIGN, 12, 12, 64'd99);
      push_word(lrmt_pkg::FUNC_ADD, 40, 20, 64'd99);
      push_word(lrmt_pkg::FUNC_ADD, 1000, 2047, 64'h7FFF_FFFF_FFFF_FFFF);
      push_word(lrmt_pkg::FUNC_QUERY, 1023, 1024, '0);
      push_word(lrmt_pkg::FUNC_QUERY, 990, 2047, '0);
      push_word(lrmt_pkg::FUNC_ADD, 1000, 1024, 64'd10);
      push_word(lrmt_pkg::FUNC_QUERY, 1000, 1001, '0);
      push_word(lrmt_pkg::FUNC_ASSIGN, 0, 1, 64'h8000_0000_0000_0000);
      push_word(lrmt_pkg::FUNC_QUERY, 0, 1, '0);
      push_word(lrmt_pkg::FUNC_ADD, 0, 512, 64'hFFFF_FFFF_FFFF_FFFF);
      push_word(lrmt_pkg::FUNC_QUERY, 0, 2, '0);
      push_word(FUNC_NONE, 0, 1024, 64'd1234);
      push_word(lrmt_pkg::FUNC_QUERY, 2047, 0, '0);
      push_word(lrmt_pkg::FUNC_QUERY, 2047, 2047, '0);
      push_word(lrmt_pkg::FUNC_ASSIGN, 300, 700, 64'd77);
      push_word(lrmt_pkg::FUNC_ADD, 500, 900, 64'd3);
      push_word(lrmt_pkg::FUNC_QUERY, 0, 1024, '0, 1'b1);

      for (int n = 0; n < 500; n++) begin
         r = $urandom_range(0, 99);
         f = (r < 40) ? lrmt_pkg::FUNC_QUERY : (r < 68) ? lrmt_pkg::FUNC_ASSIGN :
             (r < 96) ? lrmt_pkg::FUNC_ADD : FUNC_NONE;
         case ($urandom_range(0, 9))
            0: begin
               lo = $urandom_range(0, 2047);
               hi = $urandom_range(0, 2047);
            end
            1: begin
               lo = $urandom_range(0, 1024);
               hi = lo;
            end
            2: begin
               lo = $urandom_range(0, 1023);
               hi = lo + 1;
            end
            default: begin
               lo = $urandom_range(0, 1023);
               hi = lo + $urandom_range(1, ($urandom_range(0, 3) == 0) ? 1024 : 64);
               if (hi > 1024) hi = 1024;
            end
         endcase
         push_word(f, lo, hi, rand_operand(), (n % 170) == 169);
      end

      repeat (12) @(negedge clock);
      reset <= 1'b0;
      wait (word_q.size() == 0 && !req_valid);
      wait (max_q.size() == 0);
      repeat (400) @(posedge clock);
      if (errors == 0 && max_q.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
